// ===== rtl/pptt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pptt_pkg
// Shared types, widths and codes for the position PID trajectory tracker.
// ----------------------------------------------------------------------------
package pptt_pkg;

  localparam int ANGLE_W = 16;
  localparam int ERR_W   = 17;
  localparam int DERR_W  = 18;
  localparam int SUM_W   = 24;
  localparam int GAIN_W  = 32;
  localparam int IDX_W   = 13;
  localparam int ACC_W   = 59;
  localparam int CFG_AW  = 2;

  localparam logic [IDX_W-1:0] MAX_SAMPLES = IDX_W'(4096);

  localparam logic signed [SUM_W:0] SUM_MAX = (SUM_W + 1)'(8388607);
  localparam logic signed [SUM_W:0] SUM_MIN = -(SUM_W + 1)'(8388608);

  localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(64'sd2147483648);
  localparam logic signed [ACC_W-1:0] ACC_LO = -ACC_W'(64'sd2147483648);

  localparam logic signed [ANGLE_W-1:0] DRIVE_MAX = 16'sh7fff;
  localparam logic signed [ANGLE_W-1:0] DRIVE_MIN = 16'sh8000;

  localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 32'd3277;
  localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 32'd0;
  localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = 32'd3276800;
  localparam logic [IDX_W-1:0]  TRAJ_LEN_RST   = 13'd1;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_SET_TARGET = 2'd1,
    OP_TRACK      = 2'd2
  } op_t;

  typedef enum logic [CFG_AW-1:0] {
    REG_PROP_GAIN  = 2'd0,
    REG_INTEG_GAIN = 2'd1,
    REG_DERIV_GAIN = 2'd2,
    REG_TRAJ_LEN   = 2'd3
  } reg_idx_t;

endpackage

// ===== rtl/position_pid_trajectory_tracker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_pid_trajectory_tracker
// Input word -> input register -> output register (when the output is free).
// One word per cycle unless out_tready stalls; the three-gain multiply-add and
//   saturation between the input and output registers set the clock period.
// Reset (rst_n low, synchronous): gains and length to defaults, hold mode,
//   index, target, integral, last error and last drive to zero.
// ----------------------------------------------------------------------------
module position_pid_trajectory_tracker
  import pptt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] measured_angle, [31:16] angle_value
  input  logic [1:0]  in_tuser,   // [1:0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] drive_current, [28:16] sample_index,
                                  // [29] tracking, [31:30] zero
  output logic        out_tlast,  // track_done
  input  logic        cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [GAIN_W-1:0] cfg_wdata
);

  logic [GAIN_W-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [IDX_W-1:0]  traj_len_r;

  logic                      in_valid_r;
  logic [1:0]                in_op_r;
  logic signed [ANGLE_W-1:0] in_meas_r, in_angle_r;

  logic                      track_mode_r, track_mode_nxt;
  logic [IDX_W-1:0]          traj_index_r, traj_index_nxt;
  logic signed [ANGLE_W-1:0] target_r, target_nxt;
  logic signed [SUM_W-1:0]   err_sum_r, err_sum_nxt;
  logic signed [ERR_W-1:0]   last_err_r, last_err_nxt;
  logic signed [ANGLE_W-1:0] last_drive_r, last_drive_nxt;

  logic                      out_valid_r;
  logic [31:0]               out_data_r;
  logic                      out_last_r;

  logic adv;
  logic done;

  logic signed [ANGLE_W-1:0] target_eff;
  logic signed [ERR_W-1:0]   err;
  logic signed [SUM_W:0]     sum_wide;
  logic signed [SUM_W-1:0]   sum_sat;
  logic signed [DERR_W-1:0]  derr;
  logic signed [ACC_W-1:0]   p_term, i_term, d_term, acc;
  logic signed [ANGLE_W-1:0] drive;
  logic [IDX_W:0]            idx_inc;
  logic [IDX_W-1:0]          len_eff;

  // pipeline handshake
  assign adv       = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= PROP_GAIN_RST;
      integ_gain_r <= INTEG_GAIN_RST;
      deriv_gain_r <= DERIV_GAIN_RST;
      traj_len_r   <= TRAJ_LEN_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
        REG_TRAJ_LEN:   traj_len_r   <= cfg_wdata[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_op_r    <= in_tuser;
      in_meas_r  <= $signed(in_tdata[15:0]);
      in_angle_r <= $signed(in_tdata[31:16]);
    end
  end

  // PID datapath
  always_comb begin
    target_eff = (in_op_r == OP_TICK && track_mode_r) ? in_angle_r : target_r;
    err        = ERR_W'(target_eff) - ERR_W'(in_meas_r);
    sum_wide   = (SUM_W + 1)'(err_sum_r) + (SUM_W + 1)'(err);
    if (sum_wide > SUM_MAX) begin
      sum_sat = SUM_W'(SUM_MAX);
    end else if (sum_wide < SUM_MIN) begin
      sum_sat = SUM_W'(SUM_MIN);
    end else begin
      sum_sat = sum_wide[SUM_W-1:0];
    end
    derr   = DERR_W'(err) - DERR_W'(last_err_r);
    p_term = ACC_W'($signed({1'b0, prop_gain_r}) * err);
    i_term = ACC_W'($signed({1'b0, integ_gain_r}) * sum_sat);
    d_term = ACC_W'($signed({1'b0, deriv_gain_r}) * derr);
    acc    = p_term + i_term + d_term;
    if (acc >= ACC_HI) begin
      drive = DRIVE_MAX;
    end else if (acc < ACC_LO) begin
      drive = DRIVE_MIN;
    end else begin
      drive = acc[ANGLE_W+15:16];
    end
  end

  // mode and index control
  always_comb begin
    len_eff        = (traj_len_r > MAX_SAMPLES) ? MAX_SAMPLES : traj_len_r;
    idx_inc        = {1'b0, traj_index_r} + (IDX_W + 1)'(1);
    track_mode_nxt = track_mode_r;
    traj_index_nxt = traj_index_r;
    target_nxt     = target_r;
    err_sum_nxt    = err_sum_r;
    last_err_nxt   = last_err_r;
    last_drive_nxt = last_drive_r;
    done           = 1'b0;
    case (in_op_r)
      OP_TICK: begin
        target_nxt     = target_eff;
        err_sum_nxt    = sum_sat;
        last_err_nxt   = err;
        last_drive_nxt = drive;
        if (track_mode_r) begin
          if (idx_inc >= {1'b0, len_eff}) begin
            track_mode_nxt = 1'b0;
            done           = 1'b1;
            traj_index_nxt = len_eff;
          end else begin
            traj_index_nxt = idx_inc[IDX_W-1:0];
          end
        end else begin
          traj_index_nxt = '0;
        end
      end
      OP_SET_TARGET: target_nxt = in_angle_r;
      OP_TRACK: begin
        track_mode_nxt = 1'b1;
        traj_index_nxt = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_mode_r <= 1'b0;
      traj_index_r <= '0;
      target_r     <= '0;
      err_sum_r    <= '0;
      last_err_r   <= '0;
      last_drive_r <= '0;
    end else if (adv) begin
      track_mode_r <= track_mode_nxt;
      traj_index_r <= traj_index_nxt;
      target_r     <= target_nxt;
      err_sum_r    <= err_sum_nxt;
      last_err_r   <= last_err_nxt;
      last_drive_r <= last_drive_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= {2'b00, track_mode_nxt, traj_index_nxt, last_drive_nxt};
      out_last_r <= done;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_done_leaves_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> !out_tdata[29])
    else $error("track_done with tracking still set");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    track_mode_r |-> traj_index_r < MAX_SAMPLES)
    else $error("trajectory index out of range while tracking");

  a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(in_op_r) && $stable(in_meas_r))
    else $error("input stage lost a stalled word");
`endif

endmodule

// ===== tb/position_pid_trajectory_tracker_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_pid_trajectory_tracker_tb
// Self-checking bench for the position PID trajectory tracker. A predictor of
// the hold/track PID loop runs beside the block and checks every output word
// against the oldest expectation. Directed words cover the extremes and the
// mode corners. Random phases then sweep the gains and the trajectory length
// (zero, maximum and above the sample limit), integral windup in both
// directions and one long trajectory. Both sides idle at random, with
// a long receiver hold-off and a drained pause.
// ----------------------------------------------------------------------------
module position_pid_trajectory_tracker_tb;
  import pptt_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         CYCLE_LIMIT = 200000;
  localparam int         HOLD_CYCLES = 300;
  localparam int         TAIL_CYCLES = 8;
  localparam int         LONG_TICKS  = 100;

  typedef struct packed {
    logic               done;
    logic               trk;
    logic [IDX_W-1:0]   idx;
    logic signed [15:0] drive;
  } pid_word_t;

  class pid_tracker_model;
    logic [GAIN_W-1:0] kp = PROP_GAIN_RST;
    logic [GAIN_W-1:0] ki = INTEG_GAIN_RST;
    logic [GAIN_W-1:0] kd = DERIV_GAIN_RST;
    int                traj_len = int'(TRAJ_LEN_RST);
    bit                track_on;
    int                index;
    int                target;
    int                err_sum;
    int                prev_err;
    int                last_drive;
    int                mismatches;
    pid_word_t         expected_words[$];

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    function void set_reg(reg_idx_t idx, logic [GAIN_W-1:0] val);
      case (idx)
        REG_PROP_GAIN:  kp = val;
        REG_INTEG_GAIN: ki = val;
        REG_DERIV_GAIN: kd = val;
        REG_TRAJ_LEN:   traj_len = int'(val[IDX_W-1:0]);
        default: ;
      endcase
    endfunction

    function void pid_step(int meas);
      int     err;
      longint s;
      longint acc;
      err = target - meas;
      s = longint'(err_sum) + err;
      if (s > SUM_MAX) s = SUM_MAX;
      if (s < SUM_MIN) s = SUM_MIN;
      err_sum = int'(s);
      acc = longint'(kp) * err + longint'(ki) * err_sum + longint'(kd) * (err - prev_err);
      if (acc >= (longint'(1) <<< 31)) last_drive = 32767;
      else if (acc < -(longint'(1) <<< 31)) last_drive = -32768;
      else last_drive = int'(acc >>> 16);
      prev_err = err;
    endfunction

    function void note_word(logic [1:0] op, logic signed [15:0] meas,
                            logic signed [15:0] ang);
      pid_word_t w;
      bit        done;
      int        eff_len;
      done = 1'b0;
      eff_len = (traj_len > int'(MAX_SAMPLES)) ? int'(MAX_SAMPLES) : traj_len;
      case (op)
        OP_TICK: begin
          if (track_on) begin
            target = ang;
            pid_step(meas);
            index = index + 1;
            if (index >= eff_len) begin
              track_on = 1'b0;
              done = 1'b1;
              index = eff_len;
            end
          end else begin
            pid_step(meas);
            index = 0;
          end
        end
        OP_SET_TARGET: target = ang;
        OP_TRACK: begin
          track_on = 1'b1;
          index = 0;
        end
        default: ;
      endcase
      w.drive = last_drive[15:0];
      w.idx = index[IDX_W-1:0];
      w.trk = track_on;
      w.done = done;
      expected_words.push_back(w);
    endfunction

    task check_word(logic [31:0] data, logic last);
      pid_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("output word 0x%08h with none expected", data));
      end else begin
        w = expected_words.pop_front();
        if (data[15:0] !== w.drive)
          report($sformatf("drive_current got %0d exp %0d",
                           $signed(data[15:0]), w.drive));
        if (data[28:16] !== w.idx)
          report($sformatf("sample_index got %0d exp %0d", data[28:16], w.idx));
        if (data[29] !== w.trk)
          report($sformatf("tracking got %b exp %b", data[29], w.trk));
        if (last !== w.done)
          report($sformatf("track_done got %b exp %b", last, w.done));
      end
    endtask

    function int pending();
      return expected_words.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;
  logic [1:0]        in_tuser = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [31:0]       out_tdata;
  logic              out_tlast;
  logic              cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  logic [GAIN_W-1:0] cfg_wdata = '0;

  pid_tracker_model model = new();
  bit               tx_idle = 1'b1;
  bit               rx_idle = 1'b1;
  bit               hold_req = 1'b0;
  int               cycles = 0;

  position_pid_trajectory_tracker u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        model.note_word(in_tuser, $signed(in_tdata[15:0]), $signed(in_tdata[31:16]));
      if (out_tvalid && out_tready)
        model.check_word(out_tdata, out_tlast);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("position_pid_trajectory_tracker_tb NOT OK");
      $finish;
    end
  end

  // receiver: random stalls, long hold-off on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= !rx_idle || ($urandom_range(0, 99) >= 15);
      end
    end
  end

  task automatic send_word(input logic [1:0] op, input logic [15:0] meas,
                           input logic [15:0] ang);
    while (tx_idle && $urandom_range(0, 99) < 15) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {ang, meas};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (model.pending() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [GAIN_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    model.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_gains(input logic [31:0] p, input logic [31:0] i,
                           input logic [31:0] d, input logic [12:0] len);
    wait_drain();
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_TRAJ_LEN, {19'd0, len});
  endtask

  function automatic logic [15:0] pick_angle(int center);
    logic [15:0] a;
    case ($urandom_range(0, 3))
      0, 1: a = 16'($urandom);
      2: a = 16'(center + $urandom_range(0, 200) - 100);
      default: begin
        case ($urandom_range(0, 2))
          0: a = 16'h8000;
          1: a = 16'h7fff;
          default: a = 16'h0000;
        endcase
      end
    endcase
    return a;
  endfunction

  task automatic run_random(input int n, input bit hold, input bit pause);
    int          r;
    logic [1:0]  op;
    for (int k = 0; k < n; k++) begin
      if (hold && k == n / 3) hold_req = 1'b1;
      if (pause && k == n / 2) wait_drain();
      r = $urandom_range(0, 99);
      if (r < 72) op = OP_TICK;
      else if (r < 84) op = OP_SET_TARGET;
      else if (r < 96) op = OP_TRACK;
      else op = OP_UNUSED;
      send_word(op, pick_angle(model.target), pick_angle(model.target));
    end
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: extremes and mode corners at reset settings
    send_word(OP_TICK, 16'h0000, 16'h0000);
    send_word(OP_TICK, 16'h8000, 16'h0000);
    send_word(OP_TICK, 16'h7fff, 16'h0000);
    send_word(OP_TICK, 16'h0000, 16'h0000);
    send_word(OP_SET_TARGET, 16'h0000, 16'h7fff);
    send_word(OP_TICK, 16'h8000, 16'h0000);
    send_word(OP_SET_TARGET, 16'hffff, 16'h8000);
    send_word(OP_TICK, 16'h7fff, 16'hffff);
    send_word(OP_UNUSED, 16'hffff, 16'hffff);
    send_word(OP_SET_TARGET, 16'h0000, 16'h0000);
    send_word(OP_TICK, 16'h0003, 16'h0000);
    send_word(OP_TRACK, 16'h0000, 16'h0000);
    send_word(OP_SET_TARGET, 16'h0000, 16'd100);
    send_word(OP_TRACK, 16'hffff, 16'hffff);
    send_word(OP_TICK, 16'd5, 16'd7);
    send_word(OP_TICK, 16'd0, 16'hffff);
    send_word(OP_UNUSED, 16'h0000, 16'h0000);

    set_gains(32'd0, 32'd0, 32'd0, 13'd0);
    send_word(OP_TRACK, 16'h0000, 16'h0000);
    send_word(OP_TICK, 16'h1234, 16'h4321);
    run_random(150, 1'b0, 1'b0);

    set_gains(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 13'd4096);
    run_random(150, 1'b1, 1'b0);

    set_gains(32'd65536, 32'd64, 32'd32768, 13'd5);
    run_random(200, 1'b0, 1'b1);

    tx_idle = 1'b0;
    rx_idle = 1'b0;
    set_gains($urandom_range(0, 1 << 18), $urandom_range(0, 256),
              $urandom_range(0, 1 << 18), 13'd12);
    run_random(300, 1'b0, 1'b0);
    tx_idle = 1'b1;
    rx_idle = 1'b1;

    // integral windup in both directions
    set_gains(32'd0, 32'd1, 32'd0, 13'd8);
    send_word(OP_SET_TARGET, 16'h0000, 16'h7fff);
    for (int k = 0; k < 150; k++) send_word(OP_TICK, 16'h8000, 16'($urandom));
    send_word(OP_SET_TARGET, 16'h0000, 16'h8000);
    for (int k = 0; k < 150; k++) send_word(OP_TICK, 16'h7fff, 16'($urandom));

    set_gains($urandom, $urandom, $urandom, 13'($urandom_range(1, 30)));
    run_random(200, 1'b1, 1'b0);

    set_gains(PROP_GAIN_RST, INTEG_GAIN_RST, DERIV_GAIN_RST, 13'd8191);
    run_random(100, 1'b0, 1'b0);

    // long trajectory with the length above the sample limit
    set_gains(32'd65536, 32'd0, 32'd0, 13'd8191);
    send_word(OP_TRACK, 16'h0000, 16'h0000);
    for (int k = 0; k < LONG_TICKS; k++)
      send_word(OP_TICK, pick_angle(model.target), pick_angle(model.target));

    wait_drain();
    if (model.mismatches == 0)
      $display("position_pid_trajectory_tracker_tb OK");
    else
      $display("position_pid_trajectory_tracker_tb NOT OK");
    $finish;
  end

endmodule
